// ----- rtl/sdts_pkg.sv -----
// ----------------------------------------------------------------------------
// sdts_pkg
// Shared constants, register codes and the elaboration-time functions that
// build the tanh lookup table of the saturator.
// ----------------------------------------------------------------------------
package sdts_pkg;

	// Q.16 drive arithmetic.
	localparam logic [16:0] Q16_ONE      = 17'd65536;
	localparam logic [16:0] SNAP_LIMIT   = 17'd6;
	localparam logic [17:0] BYPASS_LEVEL = 18'd656;
	localparam logic [16:0] K_1P35       = 17'd88474;
	localparam logic [17:0] SAT_MAX      = 18'd131072;
	localparam logic [17:0] MULT_MIN     = 18'd19661;
	localparam logic [17:0] MULT_MAX     = 18'd196608;
	localparam logic [63:0] Q30_ONE      = 64'h0000_0000_4000_0000;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_TARGET_DRIVE = 2'd0,
		CFG_DRIVE_MULT   = 2'd1,
		CFG_SMOOTH_COEFF = 2'd2
	} cfg_idx_t;

	// Shift-subtract division, only used while the table is elaborated.
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^-t with t and the result in Q.30, for 0 <= t <= 16.
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] u3;
		logic [63:0] u4;
		logic [63:0] r;
		u  = t >> 8;
		u2 = (u * u) >> 30;
		u3 = (u2 * u) >> 30;
		u4 = (u3 * u) >> 30;
		r  = Q30_ONE - u + u2 / 2 - u3 / 6 + u4 / 24;
		for (int i = 0; i < 8; i++) begin
			r = (r * r + 64'h2000_0000) >> 30;
		end
		return r;
	endfunction

	// Rounded tanh of point k of a table spanning [0, 8], saturated to the
	// largest sample magnitude.
	function automatic logic [63:0] tanh_point(input int k, input int sw, input int depth);
		logic [63:0] t;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] v;
		logic [63:0] smax;
		smax = (64'd1 << (sw - 1)) - 64'd1;
		t    = long_div(64'(k) << 34, 64'(depth));
		e    = exp_neg_q30(t);
		den  = Q30_ONE + e;
		num  = ((Q30_ONE - e) << (sw - 1)) + (den >> 1);
		v    = long_div(num, den);
		if (v > smax) begin
			v = smax;
		end
		return v;
	endfunction

	// Table entry, kept monotonic against its neighbor below.
	function automatic logic [63:0] tanh_entry(input int k, input int sw, input int depth);
		logic [63:0] v;
		logic [63:0] prev;
		v = tanh_point(k, sw, depth);
		if (k > 0) begin
			prev = tanh_point(k - 1, sw, depth);
			if (v < prev) begin
				v = prev;
			end
		end
		return v;
	endfunction

endpackage

// ----- rtl/sdts_mul.sv -----
// ----------------------------------------------------------------------------
// sdts_mul
// Shared unsigned multiplier with a registered product. Every multiplier
// operation of the saturator goes through this one unit.
// ----------------------------------------------------------------------------
module sdts_mul #(
	parameter int A_WIDTH = 34,
	parameter int B_WIDTH = 23
) (
	input  logic                         clk,
	input  logic [A_WIDTH-1:0]           a,
	input  logic [B_WIDTH-1:0]           b,
	output logic [A_WIDTH+B_WIDTH-1:0]   prod
);

	localparam int P_WIDTH = A_WIDTH + B_WIDTH;

	logic [P_WIDTH-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= P_WIDTH'(a) * P_WIDTH'(b);
	end

	assign prod = prod_q;

endmodule

// ----- rtl/sdts_tanh_rom.sv -----
// ----------------------------------------------------------------------------
// sdts_tanh_rom
// Tanh magnitude table of TANH_TABLE_DEPTH+1 points over [0, 8], built at
// elaboration, with a registered read port.
// ----------------------------------------------------------------------------
module sdts_tanh_rom #(
	parameter int SAMPLE_WIDTH     = 24,
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  logic                                  clk,
	input  logic [$clog2(TANH_TABLE_DEPTH+1)-1:0] addr,
	output logic [SAMPLE_WIDTH-2:0]               data
);

	import sdts_pkg::*;

	localparam int SW    = SAMPLE_WIDTH;
	localparam int DEPTH = TANH_TABLE_DEPTH;

	logic [SW-2:0] tab_w [DEPTH+1];
	logic [SW-2:0] data_q;

	for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
		localparam logic [63:0] ENTRY = tanh_entry(k, SW, DEPTH);
		assign tab_w[k] = ENTRY[SW-2:0];
	end

	always_ff @(posedge clk) begin
		data_q <= tab_w[addr];
	end

	assign data = data_q;

endmodule

// ----- rtl/smoothed_drive_tanh_saturator.sv -----
// ----------------------------------------------------------------------------
// smoothed_drive_tanh_saturator
// Stereo tanh soft clipper whose drive glides toward a target on control
// ticks.
//
// Requests arrive on the in_ channel (operation, sample_left, sample_right).
// A sample-pair request yields one result on the out_ channel; a control tick
// yields none. The three drive registers are written over the cfg_ channel,
// which is ready only while the block is idle; a write to any of the three
// re-arms the drive smoothing.
// All multiplications and table reads run through one registered multiplier
// and one table read port under a small sequencer, and in_stall is high
// while a request is in work. A shaped sample pair takes nine sequencer
// steps per channel before its result is written back. A bypassed pair goes
// straight to write-back. An armed control tick runs through the drive step,
// snap and saturation update; an unarmed one leaves the sequencer idle.
// A finished result waits in the output register while out_stall is high;
// the block still takes a following request and holds a new result back
// until the pending one is taken. Reset clears drive and saturation, arms
// the smoothing and loads the register defaults; the table needs no fill.
// ----------------------------------------------------------------------------
module smoothed_drive_tanh_saturator #(
	parameter int SAMPLE_WIDTH     = 24,
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_left,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_right,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] out_left,
	output logic signed [SAMPLE_WIDTH-1:0] out_right,
	// Configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [17:0]                    cfg_data
);

	import sdts_pkg::*;

	localparam int SW    = SAMPLE_WIDTH;
	localparam int DEPTH = TANH_TABLE_DEPTH;
	localparam int DW    = $clog2(DEPTH + 1);
	localparam int YW    = SW + 2;
	localparam int SH    = SW + 2;
	localparam int MA    = (SW + 2 > 34) ? SW + 2 : 34;
	localparam int MB    = (SW - 1 > 19) ? SW - 1 : 19;
	localparam int PW    = MA + MB;
	localparam logic [SW-2:0] SMAX = '1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S_MUL,
		ST_S_RND,
		ST_S_POS,
		ST_S_IDX,
		ST_S_ROM0,
		ST_S_ROM1,
		ST_S_DIFF,
		ST_S_FMUL,
		ST_S_INT,
		ST_C_MAG,
		ST_C_MUL,
		ST_C_STEP,
		ST_C_SNAP,
		ST_C_SAT1,
		ST_C_SAT2,
		ST_C_SAT3,
		ST_WB
	} state_t;

	state_t state_q;

	// Configuration and drive state.
	logic [16:0] target_q;
	logic [17:0] mult_q;
	logic [16:0] coeff_q;
	logic [16:0] drive_q;
	logic [17:0] sat_q;
	logic        rearm_q;

	// Working registers.
	logic signed [SW-1:0] samp_l_q;
	logic signed [SW-1:0] samp_r_q;
	logic signed [SW-1:0] res_l_q;
	logic                 ch_q;
	logic                 neg_q;
	logic [YW-1:0]        y_q;
	logic [DW-1:0]        idx_q;
	logic [SH-1:0]        frac_q;
	logic                 ovf_q;
	logic [SW-2:0]        lo_q;
	logic [SW-2:0]        diff_q;
	logic [16:0]          mag_q;
	logic                 dn_q;

	// Output register.
	logic                 out_valid_q;
	logic signed [SW-1:0] out_left_q;
	logic signed [SW-1:0] out_right_q;

	// Shared units.
	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [DW-1:0] rom_addr;
	logic [SW-2:0] rom_data;

	sdts_mul #(
		.A_WIDTH(MA),
		.B_WIDTH(MB)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	sdts_tanh_rom #(
		.SAMPLE_WIDTH    (SW),
		.TANH_TABLE_DEPTH(DEPTH)
	) u_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	// Datapath terms.
	logic signed [SW-1:0] x_sel;
	logic [SW-1:0]        a_mag;
	logic [19:0]          sat5;
	logic [18:0]          gain;
	logic                 bypass;
	logic [PW-1:0]        rnd16;
	logic [PW-1:0]        rnd32;
	logic [DW-1:0]        idx_c;
	logic                 ovf_c;
	logic [SW-1:0]        sum_c;
	logic [SW-2:0]        mag_fin;
	logic [SW-1:0]        res_c;
	logic [16:0]          mag_c;
	logic [16:0]          m_raw;
	logic [16:0]          m_one;
	logic [16:0]          m_step;
	logic [18:0]          sat_raw;
	logic [17:0]          sat_next;
	logic [16:0]          cfg_17;
	logic [17:0]          cfg_18;
	logic                 cfg_arm;

	assign x_sel  = ch_q ? samp_r_q : samp_l_q;
	// The most negative sample comes out as magnitude 1.0, which still fits.
	assign a_mag  = x_sel[SW-1] ? (~x_sel + SW'(1)) : x_sel;
	assign sat5   = {sat_q, 2'b00} + {2'b00, sat_q};
	assign gain   = 19'(65536) + 19'((sat5 + 20'd1) >> 1);
	assign bypass = ({1'b0, drive_q} < BYPASS_LEVEL) || (sat_q < BYPASS_LEVEL);

	assign rnd16 = prod + PW'(32768);
	assign rnd32 = prod + (PW'(1) << 31);

	assign idx_c   = prod[SH +: DW];
	assign ovf_c   = idx_c >= DW'(DEPTH);
	assign sum_c   = {1'b0, lo_q} + {1'b0, prod[SH +: SW-1]};
	assign mag_fin = (ovf_q || sum_c > {1'b0, SMAX}) ? SMAX : sum_c[SW-2:0];
	assign res_c   = neg_q ? (SW'(0) - {1'b0, mag_fin}) : {1'b0, mag_fin};

	assign mag_c  = (target_q >= drive_q) ? (target_q - drive_q) : (drive_q - target_q);
	assign m_raw  = rnd16[16 +: 17];
	assign m_one  = (m_raw == 17'd0 && coeff_q != 17'd0) ? 17'd1 : m_raw;
	// Never step past the target.
	assign m_step = (m_one > mag_q) ? mag_q : m_one;

	assign sat_raw  = rnd32[32 +: 19];
	assign sat_next = (sat_raw > {1'b0, SAT_MAX}) ? SAT_MAX : sat_raw[17:0];

	assign cfg_17 = cfg_data[16:0];
	assign cfg_18 = cfg_data;

	// A register write taken together with a control tick arms that tick.
	assign cfg_arm = cfg_valid && cfg_ready && (cfg_index == CFG_TARGET_DRIVE
		|| cfg_index == CFG_DRIVE_MULT || cfg_index == CFG_SMOOTH_COEFF);

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_S_MUL: begin
				mul_a = MA'(a_mag);
				mul_b = MB'(gain);
			end
			ST_S_POS: begin
				mul_a = MA'(y_q);
				mul_b = MB'(DEPTH);
			end
			ST_S_FMUL: begin
				mul_a = MA'(frac_q);
				mul_b = MB'(diff_q);
			end
			ST_C_MUL: begin
				mul_a = MA'(mag_q);
				mul_b = MB'(coeff_q);
			end
			ST_C_SAT1: begin
				mul_a = MA'(drive_q);
				mul_b = MB'(mult_q);
			end
			ST_C_SAT2: begin
				mul_a = MA'(prod[33:0]);
				mul_b = MB'(K_1P35);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The table is read at the lower point, then at the upper one.
	assign rom_addr = (state_q == ST_S_ROM1) ? (idx_q + DW'(1)) : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= '0;
			mult_q      <= 18'd65536;
			coeff_q     <= 17'd655;
			drive_q     <= '0;
			sat_q       <= '0;
			rearm_q     <= 1'b1;
			samp_l_q    <= '0;
			samp_r_q    <= '0;
			res_l_q     <= '0;
			ch_q        <= 1'b0;
			neg_q       <= 1'b0;
			y_q         <= '0;
			idx_q       <= '0;
			frac_q      <= '0;
			ovf_q       <= 1'b0;
			lo_q        <= '0;
			diff_q      <= '0;
			mag_q       <= '0;
			dn_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_left_q  <= '0;
			out_right_q <= '0;
		end else begin
			// Write-back refills the output register itself.
			if (out_valid_q && !out_stall && state_q != ST_WB) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						samp_l_q <= sample_left;
						samp_r_q <= sample_right;
						ch_q     <= 1'b0;
						if (operation) begin
							if (rearm_q || cfg_arm) begin
								state_q <= ST_C_MAG;
							end
						end else if (bypass) begin
							res_l_q  <= sample_left;
							state_q  <= ST_WB;
						end else begin
							state_q <= ST_S_MUL;
						end
					end
				end
				ST_S_MUL: begin
					neg_q   <= x_sel[SW-1];
					state_q <= ST_S_RND;
				end
				ST_S_RND: begin
					y_q     <= rnd16[16 +: YW];
					state_q <= ST_S_POS;
				end
				ST_S_POS: begin
					state_q <= ST_S_IDX;
				end
				ST_S_IDX: begin
					ovf_q   <= ovf_c;
					idx_q   <= ovf_c ? '0 : idx_c;
					frac_q  <= prod[SH-1:0];
					state_q <= ST_S_ROM0;
				end
				ST_S_ROM0: begin
					state_q <= ST_S_ROM1;
				end
				ST_S_ROM1: begin
					lo_q    <= rom_data;
					state_q <= ST_S_DIFF;
				end
				ST_S_DIFF: begin
					diff_q  <= rom_data - lo_q;
					state_q <= ST_S_FMUL;
				end
				ST_S_FMUL: begin
					state_q <= ST_S_INT;
				end
				ST_S_INT: begin
					if (!ch_q) begin
						res_l_q <= res_c;
						ch_q    <= 1'b1;
						state_q <= ST_S_MUL;
					end else begin
						// The right result waits in the sample register.
						samp_r_q <= res_c;
						state_q  <= ST_WB;
					end
				end
				ST_C_MAG: begin
					mag_q   <= mag_c;
					dn_q    <= drive_q > target_q;
					state_q <= ST_C_MUL;
				end
				ST_C_MUL: begin
					state_q <= ST_C_STEP;
				end
				ST_C_STEP: begin
					drive_q <= dn_q ? (drive_q - m_step) : (drive_q + m_step);
					state_q <= ST_C_SNAP;
				end
				ST_C_SNAP: begin
					if (mag_c <= SNAP_LIMIT) begin
						drive_q <= target_q;
						rearm_q <= 1'b0;
					end
					state_q <= ST_C_SAT1;
				end
				ST_C_SAT1: begin
					state_q <= ST_C_SAT2;
				end
				ST_C_SAT2: begin
					state_q <= ST_C_SAT3;
				end
				ST_C_SAT3: begin
					sat_q   <= sat_next;
					state_q <= ST_IDLE;
				end
				ST_WB: begin
					if (!out_valid_q || !out_stall) begin
						out_left_q  <= res_l_q;
						out_right_q <= samp_r_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TARGET_DRIVE: begin
						target_q <= (cfg_17 > Q16_ONE) ? Q16_ONE : cfg_17;
						rearm_q  <= 1'b1;
					end
					CFG_DRIVE_MULT: begin
						if (cfg_18 < MULT_MIN) begin
							mult_q <= MULT_MIN;
						end else if (cfg_18 > MULT_MAX) begin
							mult_q <= MULT_MAX;
						end else begin
							mult_q <= cfg_18;
						end
						rearm_q <= 1'b1;
					end
					CFG_SMOOTH_COEFF: begin
						coeff_q <= (cfg_17 > Q16_ONE) ? Q16_ONE : cfg_17;
						rearm_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;

	// Smoothing only disarms once the drive has landed on the target.
	a_disarm_on_target: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rearm_q) |-> (drive_q == target_q))
		else $error("smoothing disarmed away from the target");

	// Steps never overshoot, so the drive stays within the target range.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q <= Q16_ONE)
		else $error("smoothed drive above unity");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q <= SAT_MAX)
		else $error("saturation factor above its clamp");

	// A new result is only loaded from the write-back step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WB))
		else $error("result presented outside write-back");

	// A control tick never produces a result.
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C_SAT3) |=> !$rose(out_valid_q))
		else $error("control tick produced a result");

endmodule
